>>> rtl/gbn_pkg.sv
// shared types and constants for the greedy box suppression block
`default_nettype none

package gbn_pkg;

	// register index of the overlap threshold
	localparam logic REG_IOU_THR = 1'b0;

	// threshold value after reset, Q1.8
	localparam logic [8:0] IOU_THR_RESET = 9'd115;

	// widths of the result fields
	localparam int INDEX_W = 12;
	localparam int TOTAL_W = 7;

	// one incoming detection box
	typedef struct packed {
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
		logic        [14:0] box_width;
		logic        [14:0] box_height;
		logic               last_box;
	} in_box_t;

	// one suppression decision
	typedef struct packed {
		logic               keep;
		logic [INDEX_W-1:0] box_index;
		logic [TOTAL_W-1:0] kept_total;
		logic               list_full;
	} out_res_t;

	// one box as held in the kept list, edges and area
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [16:0] right;
		logic signed [16:0] bottom;
		logic        [29:0] area;
	} entry_t;

	// pipeline status of the overlap unit
	typedef struct packed {
		logic hit_valid;
		logic busy;
	} iou_stat_t;

endpackage

`default_nettype wire

>>> rtl/greedy_box_nms.sv
// Greedy non-maximum suppression by intersection over union.
// Boxes arrive on the in channel (valid/ready) sorted by descending score,
// one transaction per box; each box yields exactly one decision transaction
// on the out channel (valid/ready): keep, index in set, kept count, full.
// Each box is tested against every kept box of the current set through one
// pipelined overlap unit fed by a single memory read port, one kept entry
// per cycle. Each box sweeps the kept list, kept_count entries and at
// most MAX_KEPT, and the length of that sweep sets how long the box takes.
// in_ready is high only while the block is idle. A finished decision
// sits in the output register, and the next box is taken meanwhile; that box
// holds its own decision until the output register is free, so a stalled
// receiver stalls the block after one box.
// A box flagged last_box clears the kept list and the set position after
// its decision. Reset clears the list, the position and the output valid,
// and sets the threshold to 115/256. The threshold is written through the
// APB port at byte address 0 while the block is idle: the user must keep to
// this, as the block itself does not enforce it.
`default_nettype none

module greedy_box_nms
	import gbn_pkg::*;
#(
	parameter int MAX_KEPT      = 64,
	parameter int MAX_SET_BOXES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// box input
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire in_box_t     in_box,
	// decision output
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      out_res_t    out_res,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int TOT_W  = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
	localparam int LIM_I  = (MAX_SET_BOXES - 1 > 4095) ? 4095 : MAX_SET_BOXES - 1;
	localparam logic [INDEX_W-1:0] IDX_LIM  = INDEX_W'(LIM_I);
	localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(MAX_KEPT);
	localparam logic [TOT_W-1:0]   TOT_SAT  = TOT_W'(127);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE
	} state_t;

	state_t              state_q;
	entry_t              box_q;
	logic                last_q;
	logic                supp_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    scan_q;
	logic [INDEX_W-1:0]  pos_q;
	logic [8:0]          thr_q;
	logic                out_valid_q;
	out_res_t            out_res_q;

	logic                rd_en;
	logic                rd_valid;
	entry_t              rd_data;
	iou_stat_t           iou_stat;
	logic                full;
	logic                store_box;
	logic                can_emit;
	logic [CNT_W-1:0]    cnt_next;
	logic [TOT_W-1:0]    cnt_ext;
	logic [TOTAL_W-1:0]  total;
	logic                cfg_wr;

	// configuration register access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_IOU_THR) ? {23'd0, thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= IOU_THR_RESET;
		end else if (cfg_wr && paddr[2] == REG_IOU_THR) begin
			thr_q <= pwdata[8:0];
		end
	end

	// handshakes
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign can_emit  = !out_valid_q || out_ready;

	// decision terms
	assign full      = (cnt_q == CNT_FULL);
	assign store_box = !supp_q && !full;
	assign cnt_next  = cnt_q + CNT_W'(store_box);
	assign cnt_ext   = TOT_W'(cnt_next);
	assign total     = (cnt_ext > TOT_SAT) ? TOTAL_W'(TOT_SAT) : cnt_ext[TOTAL_W-1:0];

	// kept list read sweep
	assign rd_en = (state_q == S_SCAN) && (scan_q != cnt_q);

	gbn_store #(
		.MAX_KEPT(MAX_KEPT),
		.AW      (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   ((state_q == S_DECIDE) && can_emit && store_box),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (box_q),
		.rd_en   (rd_en),
		.rd_addr (scan_q[AW-1:0]),
		.rd_valid(rd_valid),
		.rd_data (rd_data)
	);

	gbn_iou u_iou (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rd_valid),
		.kept    (rd_data),
		.cand    (box_q),
		.thr     (thr_q),
		.stat    (iou_stat)
	);

	// sequencer with the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			box_q       <= '0;
			last_q      <= 1'b0;
			supp_q      <= 1'b0;
			cnt_q       <= '0;
			scan_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (iou_stat.hit_valid) begin
				supp_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						box_q.left   <= in_box.box_left;
						box_q.top    <= in_box.box_top;
						box_q.right  <= {in_box.box_left[15], in_box.box_left} +
							{2'b00, in_box.box_width};
						box_q.bottom <= {in_box.box_top[15], in_box.box_top} +
							{2'b00, in_box.box_height};
						box_q.area   <= 30'(in_box.box_width) * 30'(in_box.box_height);
						last_q       <= in_box.last_box;
						supp_q       <= 1'b0;
						scan_q       <= '0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_valid && !iou_stat.busy) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (can_emit) begin
						out_valid_q          <= 1'b1;
						out_res_q.keep       <= !supp_q;
						out_res_q.box_index  <= pos_q;
						out_res_q.kept_total <= total;
						out_res_q.list_full  <= !supp_q && full;
						if (last_q) begin
							cnt_q <= '0;
							pos_q <= '0;
						end else begin
							cnt_q <= cnt_next;
							if (pos_q < IDX_LIM) begin
								pos_q <= pos_q + 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/gbn_store.sv
// kept box list memory, one write port and one registered read port
`default_nettype none

module gbn_store
	import gbn_pkg::*;
#(
	parameter int MAX_KEPT = 64,
	parameter int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output      logic          rd_valid,
	output      entry_t        rd_data
);

	entry_t mem [MAX_KEPT];

	// storage array, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	// read data valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid <= 1'b0;
		end else begin
			rd_valid <= rd_en;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gbn_iou.sv
// pipelined overlap test: intersection * 256 > threshold * union
`default_nettype none

module gbn_iou
	import gbn_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire entry_t     kept,
	input  wire entry_t     cand,
	input  wire logic [8:0] thr,
	output      iou_stat_t  stat
);

	logic signed [16:0] x_lo, x_hi, y_lo, y_hi;
	logic        [14:0] ox, oy;
	logic        [29:0] inter;
	logic        [30:0] uni;
	logic        [29:0] inter_s2, karea_s2;
	logic        [29:0] inter_s3;
	logic        [39:0] prod_s3;
	logic               valid_s2, valid_s3;
	logic               hit;

	// overlap along each axis, zero when disjoint
	always_comb begin
		x_lo = (cand.left > kept.left) ?
			{cand.left[15], cand.left} : {kept.left[15], kept.left};
		x_hi = (cand.right < kept.right) ? cand.right : kept.right;
		y_lo = (cand.top > kept.top) ?
			{cand.top[15], cand.top} : {kept.top[15], kept.top};
		y_hi = (cand.bottom < kept.bottom) ? cand.bottom : kept.bottom;
		ox = (x_hi > x_lo) ? 15'(x_hi - x_lo) : 15'd0;
		oy = (y_hi > y_lo) ? 15'(y_hi - y_lo) : 15'd0;
		inter = 30'(ox) * 30'(oy);
	end

	// union from the registered intersection
	assign uni = 31'(cand.area) + 31'(karea_s2) - 31'(inter_s2);

	// stage registers
	always_ff @(posedge clk) begin
		inter_s2 <= inter;
		karea_s2 <= kept.area;
		inter_s3 <= inter_s2;
		prod_s3  <= 40'(thr) * 40'(uni);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
		end
	end

	// final compare on the last stage
	assign hit = {2'b00, inter_s3, 8'h00} > prod_s3;

	assign stat.hit_valid = valid_s3 & hit;
	assign stat.busy      = valid_s2 | valid_s3;

endmodule

`default_nettype wire

>>> sim/tb_greedy_box_nms.sv
// testbench for greedy_box_nms: directed table, random box sets, long set, scoreboard check
`default_nettype none

module tb_greedy_box_nms;
	import gbn_pkg::*;

	localparam int MAX_KEPT      = 64;
	localparam int INDEX_MAX     = 4095;
	localparam int SETTLE_CYCLES = MAX_KEPT + 16;
	localparam int HOLD_AT       = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_ITEMS   = 100;
	localparam int LONG_SET      = 160;
	localparam int LIMIT_TIME    = 40000000;
	localparam int PRINT_CAP     = 50;
	localparam logic [2:0] THR_ADDR = {REG_IOU_THR, 2'b00};

	typedef struct {
		in_box_t  box;
		bit       typed;
		out_res_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_box_t     in_box = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_res_t    out_res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// behavioral copy of the kept list
	logic signed [15:0] list_left   [MAX_KEPT];
	logic signed [15:0] list_top    [MAX_KEPT];
	logic signed [16:0] list_right  [MAX_KEPT];
	logic signed [16:0] list_bottom [MAX_KEPT];
	logic        [29:0] list_area   [MAX_KEPT];
	int          list_count = 0;
	int          set_pos = 0;
	logic [8:0]  thr_q08 = IOU_THR_RESET;

	out_res_t decision_q [$];
	dir_row_t dir_rows [$];

	int idle_pct = 24;
	int clu_x [3];
	int clu_y [3];
	logic [15:0] corner_pos [4] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF};
	logic [14:0] corner_len [3] = '{15'd0, 15'd1, 15'h7FFF};
	logic [8:0]  thr_plan [7] = '{9'd0, 9'd256, 9'd200, 9'd64, 9'd255, 9'd1, 9'd115};

	int n_errors = 0;
	int n_checked = 0;
	int n_items = 0;
	int n_sets = 0;
	int n_kept = 0;
	int n_suppressed = 0;
	int n_full = 0;
	int n_thr_writes = 0;
	int max_index = 0;

	greedy_box_nms u_top (.*);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(LIMIT_TIME);
		$display("tb_greedy_box_nms: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (n_errors < PRINT_CAP)
			$display("mismatch at decision %0d: %s got %0d, expected %0d",
				n_checked, what, got, want);
		n_errors++;
	endtask

	// length of the overlap of two half-open spans, zero when disjoint
	function automatic longint span_overlap(input int a0, input int a1, input int b0,
			input int b1);
		int lo;
		int hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? longint'(hi - lo) : 64'sd0;
	endfunction

	// greedy suppression decision for one box, updates the kept list
	function automatic out_res_t nms_decide(input in_box_t b);
		int       l, t, r, btm;
		longint   area, inter, uni;
		bit       keep, full;
		out_res_t res;
		l = int'($signed(b.box_left));
		t = int'($signed(b.box_top));
		r = l + int'(b.box_width);
		btm = t + int'(b.box_height);
		area = longint'(b.box_width) * longint'(b.box_height);
		keep = 1'b1;
		full = 1'b0;
		for (int i = 0; i < list_count && keep; i++) begin
			inter = span_overlap(l, r, int'(list_left[i]), int'(list_right[i])) *
				span_overlap(t, btm, int'(list_top[i]), int'(list_bottom[i]));
			uni = area + longint'(list_area[i]) - inter;
			if (inter * 256 > longint'(thr_q08) * uni)
				keep = 1'b0;
		end
		if (keep) begin
			if (list_count < MAX_KEPT) begin
				list_left[list_count]   = 16'(l);
				list_top[list_count]    = 16'(t);
				list_right[list_count]  = 17'(r);
				list_bottom[list_count] = 17'(btm);
				list_area[list_count]   = 30'(area);
				list_count++;
			end else begin
				full = 1'b1;
			end
		end
		res.keep = keep;
		res.box_index = INDEX_W'((set_pos > INDEX_MAX) ? INDEX_MAX : set_pos);
		res.kept_total = TOTAL_W'(list_count);
		res.list_full = full;
		if (b.last_box) begin
			list_count = 0;
			set_pos = 0;
		end else if (set_pos < INDEX_MAX) begin
			set_pos++;
		end
		return res;
	endfunction

	// random box: mostly clustered around the set's centers, some noise and corner cases
	function automatic in_box_t gen_box(input bit ends_set);
		in_box_t     b;
		logic [62:0] raw;
		int          c;
		int          pick;
		pick = $urandom_range(0, 99);
		c = $urandom_range(0, 2);
		b.box_left = 16'(clu_x[c] + int'($urandom_range(0, 512)) - 256);
		b.box_top = 16'(clu_y[c] + int'($urandom_range(0, 512)) - 256);
		b.box_width = 15'($urandom_range(32, 2048));
		b.box_height = 15'($urandom_range(32, 2048));
		if (pick >= 85) begin
			raw = {$urandom, 31'($urandom)};
			b = raw;
		end else if (pick >= 75) begin
			case ($urandom_range(0, 2))
				0: b.box_width = '0;
				1: b.box_height = '0;
				default: begin
					b.box_width = '0;
					b.box_height = '0;
				end
			endcase
		end else if (pick >= 70) begin
			b.box_left = corner_pos[$urandom_range(0, 3)];
			b.box_top = corner_pos[$urandom_range(0, 3)];
			b.box_width = corner_len[$urandom_range(0, 2)];
			b.box_height = corner_len[$urandom_range(0, 2)];
		end
		b.last_box = ends_set;
		return b;
	endfunction

	function automatic void add_row(input int l, input int t, input int w, input int h,
			input bit ends_set, input bit typed, input out_res_t res);
		dir_row_t row;
		row.box.box_left = 16'(l);
		row.box.box_top = 16'(t);
		row.box.box_width = 15'(w);
		row.box.box_height = 15'(h);
		row.box.last_box = ends_set;
		row.typed = typed;
		row.res = res;
		dir_rows = {dir_rows, row};
	endfunction

	// offer one box, predict its decision once the transaction is taken
	task automatic send_box(input in_box_t b, input bit typed, input out_res_t typed_res);
		out_res_t predicted;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_box <= b;
		do @(posedge clk); while (!in_ready);
		predicted = nms_decide(b);
		decision_q = {decision_q, typed ? typed_res : predicted};
		n_items++;
		if (b.last_box)
			n_sets++;
	endtask

	// stop offering and wait for every outstanding decision
	task automatic drain_decisions();
		in_valid <= 1'b0;
		while (decision_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write of the threshold, then read it back
	task automatic set_threshold(input logic [8:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= THR_ADDR;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		thr_q08 = val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[8:0] !== val)
			report_mismatch("threshold readback", longint'(prdata[8:0]), longint'(val));
		psel <= 1'b0;
		penable <= 1'b0;
		n_thr_writes++;
	endtask

	task automatic check_decision(input out_res_t got);
		out_res_t want;
		if (decision_q.size() == 0) begin
			report_mismatch("decision with none pending", longint'(got), longint'(0));
			return;
		end
		want = decision_q.pop_front();
		if (got.keep !== want.keep)
			report_mismatch("keep", longint'(got.keep), longint'(want.keep));
		if (got.box_index !== want.box_index)
			report_mismatch("box_index", longint'(got.box_index),
				longint'(want.box_index));
		if (got.kept_total !== want.kept_total)
			report_mismatch("kept_total", longint'(got.kept_total),
				longint'(want.kept_total));
		if (got.list_full !== want.list_full)
			report_mismatch("list_full", longint'(got.list_full),
				longint'(want.list_full));
		n_checked++;
		if (got.keep === 1'b1)
			n_kept++;
		else
			n_suppressed++;
		if (got.list_full === 1'b1)
			n_full++;
		if (int'(got.box_index) > max_index)
			max_index = int'(got.box_index);
	endtask

	// receiver: check each transaction, random stalls and one long hold-off
	initial begin : receiver
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_decision(out_res);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (n_checked >= HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int  set_len;
		int  phase_items;
		bit  broken;
		in_box_t b;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset threshold
		add_row(0, 0, 256, 256, 0, 1, out_res_t'({1'b1, 12'd0, 7'd1, 1'b0}));
		add_row(0, 0, 256, 256, 0, 1, out_res_t'({1'b0, 12'd1, 7'd1, 1'b0}));
		add_row(4096, 4096, 256, 256, 0, 1, out_res_t'({1'b1, 12'd2, 7'd2, 1'b0}));
		add_row(128, 0, 256, 256, 0, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, '0);
		add_row(0, 0, 0, 0, 0, 0, '0);
		add_row(-32768, -32768, 32767, 32767, 0, 0, '0);
		add_row(32767, 32767, 32767, 32767, 0, 0, '0);
		add_row(-1, -1, 1, 1, 0, 0, '0);
		add_row(16'h5555, 16'hAAAA, 15'h2AAA, 15'h5555, 0, 0, '0);
		add_row(16'hAAAA, 16'h5555, 15'h5555, 15'h2AAA, 0, 0, '0);
		add_row(0, 0, 32767, 32767, 0, 0, '0);
		add_row(64, 64, 128, 128, 1, 0, '0);
		add_row(0, 0, 256, 256, 0, 1, out_res_t'({1'b1, 12'd0, 7'd1, 1'b0}));
		add_row(0, 0, 256, 256, 1, 1, out_res_t'({1'b0, 12'd1, 7'd1, 1'b0}));
		add_row(0, 0, 256, 256, 1, 1, out_res_t'({1'b1, 12'd0, 7'd1, 1'b0}));
		add_row(0, 0, 0, 0, 1, 1, out_res_t'({1'b1, 12'd0, 7'd1, 1'b0}));
		foreach (dir_rows[i])
			send_box(dir_rows[i].box, dir_rows[i].typed, dir_rows[i].res);

		// random sets, one threshold per phase, first set of each phase long
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_decisions();
			set_threshold((p < 7) ? thr_plan[p] : 9'($urandom_range(0, 256)));
			idle_pct = (p == 3) ? 0 : 24;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if (phase_items == 0)
					set_len = $urandom_range(60, 90);
				else if ($urandom_range(0, 7) == 0)
					set_len = $urandom_range(40, 90);
				else
					set_len = $urandom_range(1, 24);
				for (int c = 0; c < 3; c++) begin
					clu_x[c] = int'($urandom_range(0, 40000)) - 20000;
					clu_y[c] = int'($urandom_range(0, 40000)) - 20000;
				end
				// some sets run on without a closing box
				broken = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < set_len; k++)
					send_box(gen_box(k == set_len - 1 && !broken), 0, '0);
				phase_items += set_len;
			end
		end

		// one long set of heavily overlapping boxes at a zero threshold
		drain_decisions();
		set_threshold(9'd0);
		idle_pct = 24;
		for (int k = 0; k < LONG_SET; k++) begin
			b.box_left = 16'($urandom_range(0, 800));
			b.box_top = 16'($urandom_range(0, 800));
			b.box_width = 15'($urandom_range(16, 800));
			b.box_height = 15'($urandom_range(16, 800));
			b.last_box = (k == LONG_SET - 1);
			send_box(b, 0, '0);
		end
		drain_decisions();

		$display("covered %0d boxes in %0d closed sets over %0d threshold writes",
			n_items, n_sets, n_thr_writes);
		$display("%0d decisions: %0d kept, %0d suppressed, %0d list full, top index %0d",
			n_checked, n_kept, n_suppressed, n_full, max_index);
		if (n_errors == 0 && decision_q.size() == 0)
			$display("tb_greedy_box_nms: done, clean");
		else
			$display("tb_greedy_box_nms: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
